[design/dtpg_pkg.sv]
package dtpg_pkg;

  // Field widths of the item formats
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 19;
  localparam int PHASE_W   = 8;
  localparam int PAL_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  // Coordinate compare width, holds canvas sizes up to 4095
  localparam int CMP_W = 12;

  // Divider length: one quotient bit per stage, sized for the x offset
  localparam int DIV_W = X_W;

  // Band generator constants
  localparam logic [PHASE_W-1:0] PHASE_STEP = 8'd8;
  localparam logic [COLOR_W-1:0] MASK_RG    = 8'hE0;
  localparam logic [COLOR_W-1:0] MASK_B     = 8'hC0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_LEFT    = 3'd1,
    REG_TOP     = 3'd2,
    REG_RWIDTH  = 3'd3,
    REG_RHEIGHT = 3'd4,
    REG_CELLW   = 3'd5,
    REG_CELLH   = 3'd6,
    REG_PALETTE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic             mode;
    logic [X_W-1:0]   left;
    logic [Y_W-1:0]   top;
    logic [X_W-1:0]   rwidth;
    logic [Y_W-1:0]   rheight;
    logic [X_W-1:0]   cellw;
    logic [Y_W-1:0]   cellh;
    logic [PAL_W-1:0] palette;
  } cfg_t;

  // Per-item sideband carried alongside the divider
  typedef struct packed {
    logic               use_tile;
    logic               wr;
    logic [COLOR_W-1:0] color_base;
    logic [ADDR_W-1:0]  addr;
  } side_t;

endpackage

[design/dtpg_front.sv]
module dtpg_front #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 480
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dtpg_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dtpg_pkg::X_W-1:0]         in_x,
  input  logic [dtpg_pkg::Y_W-1:0]         in_y,
  input  logic                             in_fb,
  output logic                             dv_valid,
  input  logic                             dv_ready,
  output logic [dtpg_pkg::X_W-1:0]         dv_rx,
  output logic [dtpg_pkg::Y_W-1:0]         dv_ry,
  output dtpg_pkg::side_t                  dv_side,
  output logic [dtpg_pkg::PHASE_W-1:0]     band_phase
);

  logic [dtpg_pkg::PHASE_W-1:0]   band_phase_r, band_phase_nxt;

  logic                           a_valid_r;
  logic [dtpg_pkg::X_W-1:0]       a_x_r;
  logic [dtpg_pkg::Y_W-1:0]       a_y_r;
  logic [dtpg_pkg::PHASE_W-1:0]   a_phase_r;

  logic                           b_valid_r;
  logic [dtpg_pkg::X_W-1:0]       b_rx_r;
  logic [dtpg_pkg::Y_W-1:0]       b_ry_r;
  dtpg_pkg::side_t                b_side_r, b_side_nxt;

  logic                           ld_a, ld_b, accept;
  logic                           on_canvas, in_rect;
  logic [dtpg_pkg::X_W:0]         rect_right;
  logic [dtpg_pkg::Y_W:0]         rect_bottom;
  logic [dtpg_pkg::COLOR_W-1:0]   r_sum, g_dif, b_sum, obl_color;

  assign ld_b     = !b_valid_r || dv_ready;
  assign ld_a     = !a_valid_r || ld_b;
  assign in_ready = ld_a;
  assign accept   = in_valid && ld_a;

  // band counter steps ahead of the first pixel of a frame
  always_comb begin
    band_phase_nxt = band_phase_r;
    if (accept && cfg.mode && in_fb) begin
      band_phase_nxt = band_phase_r + dtpg_pkg::PHASE_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_phase_r <= '0;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
    end else begin
      band_phase_r <= band_phase_nxt;
      if (ld_a) begin
        a_valid_r <= in_valid;
      end
      if (ld_b) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_x_r     <= in_x;
      a_y_r     <= in_y;
      a_phase_r <= band_phase_nxt;
    end
    if (ld_b) begin
      b_rx_r   <= a_x_r - cfg.left;
      b_ry_r   <= a_y_r - cfg.top;
      b_side_r <= b_side_nxt;
    end
  end

  // stage B: window tests, band colour, linear address
  always_comb begin
    on_canvas = (dtpg_pkg::CMP_W'(a_x_r) < dtpg_pkg::CMP_W'(CANVAS_WIDTH)) &&
                (dtpg_pkg::CMP_W'(a_y_r) < dtpg_pkg::CMP_W'(CANVAS_HEIGHT));
    rect_right  = {1'b0, cfg.left} + {1'b0, cfg.rwidth};
    rect_bottom = {1'b0, cfg.top} + {1'b0, cfg.rheight};
    in_rect = on_canvas &&
              (a_x_r >= cfg.left) && ({1'b0, a_x_r} < rect_right) &&
              (a_y_r >= cfg.top) && ({1'b0, a_y_r} < rect_bottom);

    r_sum = a_phase_r + a_x_r[dtpg_pkg::COLOR_W-1:0] + a_y_r[dtpg_pkg::COLOR_W-1:0];
    g_dif = a_phase_r - a_y_r[dtpg_pkg::COLOR_W-1:0];
    b_sum = a_phase_r + a_y_r[dtpg_pkg::COLOR_W-1:0];
    obl_color = (r_sum & dtpg_pkg::MASK_RG) |
                ((g_dif & dtpg_pkg::MASK_RG) >> 3) |
                ((b_sum & dtpg_pkg::MASK_B) >> 6);

    b_side_nxt.use_tile   = !cfg.mode && in_rect;
    b_side_nxt.wr         = cfg.mode ? on_canvas : in_rect;
    b_side_nxt.color_base = (cfg.mode && on_canvas) ? obl_color : '0;
    b_side_nxt.addr       = dtpg_pkg::ADDR_W'(a_y_r) * dtpg_pkg::ADDR_W'(CANVAS_WIDTH) +
                            dtpg_pkg::ADDR_W'(a_x_r);
  end

  assign dv_valid   = b_valid_r;
  assign dv_rx      = b_rx_r;
  assign dv_ry      = b_ry_r;
  assign dv_side    = b_side_r;
  assign band_phase = band_phase_r;

endmodule

[design/dtpg_div.sv]
module dtpg_div #(
  parameter int GRID_ROWS = 2,
  parameter int GRID_COLS = 4,
  localparam int CQW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1,
  localparam int RQW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dtpg_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dtpg_pkg::X_W-1:0]   in_rx,
  input  logic [dtpg_pkg::Y_W-1:0]   in_ry,
  input  dtpg_pkg::side_t            in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CQW-1:0]             out_col,
  output logic [RQW-1:0]             out_row,
  output dtpg_pkg::side_t            out_side
);

  localparam int W = dtpg_pkg::DIV_W;

  // restoring division, one quotient bit per stage; the quotient itself is
  // never kept, only its residue modulo the grid size
  logic [W-1:0]    v_r, v_prev, v_nxt;
  logic [W:0]      ld;
  logic [W-1:0]    dx_r [W];
  logic [W-1:0]    dy_r [W];
  logic [W-1:0]    remx_r [W];
  logic [W-1:0]    remy_r [W];
  logic [CQW-1:0]  qx_r [W];
  logic [RQW-1:0]  qy_r [W];
  dtpg_pkg::side_t side_r [W];

  logic [W-1:0]    dx_nxt [W];
  logic [W-1:0]    dy_nxt [W];
  logic [W-1:0]    remx_nxt [W];
  logic [W-1:0]    remy_nxt [W];
  logic [CQW-1:0]  qx_nxt [W];
  logic [RQW-1:0]  qy_nxt [W];
  dtpg_pkg::side_t side_nxt [W];

  logic [W-1:0]    pdx, pdy, premx, premy, dvx, dvy;
  logic [CQW-1:0]  pqx;
  logic [RQW-1:0]  pqy;
  logic [W:0]      tx, ty;

  function automatic logic [CQW-1:0] col_step(input logic [CQW-1:0] q, input logic b);
    logic [CQW:0] t;
    t = {q, b};
    if (t >= (CQW+1)'(GRID_COLS)) begin
      t = t - (CQW+1)'(GRID_COLS);
    end
    return t[CQW-1:0];
  endfunction

  function automatic logic [RQW-1:0] row_step(input logic [RQW-1:0] q, input logic b);
    logic [RQW:0] t;
    t = {q, b};
    if (t >= (RQW+1)'(GRID_ROWS)) begin
      t = t - (RQW+1)'(GRID_ROWS);
    end
    return t[RQW-1:0];
  endfunction

  // zero cell size behaves as one
  assign dvx = (cfg.cellw == '0) ? W'(1) : cfg.cellw;
  assign dvy = (cfg.cellh == '0) ? W'(1) : W'(cfg.cellh);

  always_comb begin
    ld[W] = out_ready;
    for (int j = W - 1; j >= 0; j--) begin
      ld[j] = !v_r[j] || ld[j+1];
    end
  end

  assign v_prev = {v_r[W-2:0], in_valid};
  assign v_nxt  = (v_prev & ld[W-1:0]) | (v_r & ~ld[W-1:0]);

  always_comb begin
    for (int j = 0; j < W; j++) begin
      if (j == 0) begin
        pdx          = in_rx;
        pdy          = W'(in_ry);
        premx        = '0;
        premy        = '0;
        pqx          = '0;
        pqy          = '0;
        side_nxt[j]  = in_side;
      end else begin
        pdx          = dx_r[j-1];
        pdy          = dy_r[j-1];
        premx        = remx_r[j-1];
        premy        = remy_r[j-1];
        pqx          = qx_r[j-1];
        pqy          = qy_r[j-1];
        side_nxt[j]  = side_r[j-1];
      end
      tx = {premx, pdx[W-1]};
      ty = {premy, pdy[W-1]};
      dx_nxt[j] = pdx << 1;
      dy_nxt[j] = pdy << 1;
      if (tx >= {1'b0, dvx}) begin
        remx_nxt[j] = W'(tx - {1'b0, dvx});
        qx_nxt[j]   = col_step(pqx, 1'b1);
      end else begin
        remx_nxt[j] = tx[W-1:0];
        qx_nxt[j]   = col_step(pqx, 1'b0);
      end
      if (ty >= {1'b0, dvy}) begin
        remy_nxt[j] = W'(ty - {1'b0, dvy});
        qy_nxt[j]   = row_step(pqy, 1'b1);
      end else begin
        remy_nxt[j] = ty[W-1:0];
        qy_nxt[j]   = row_step(pqy, 1'b0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < W; j++) begin
      if (ld[j]) begin
        dx_r[j]   <= dx_nxt[j];
        dy_r[j]   <= dy_nxt[j];
        remx_r[j] <= remx_nxt[j];
        remy_r[j] <= remy_nxt[j];
        qx_r[j]   <= qx_nxt[j];
        qy_r[j]   <= qy_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[W-1];
  assign out_col   = qx_r[W-1];
  assign out_row   = qy_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

[design/dtpg_out.sv]
module dtpg_out #(
  parameter int GRID_ROWS = 2,
  parameter int GRID_COLS = 4,
  localparam int CQW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1,
  localparam int RQW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dtpg_pkg::PAL_W-1:0]     palette,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CQW-1:0]                 in_col,
  input  logic [RQW-1:0]                 in_row,
  input  dtpg_pkg::side_t                in_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dtpg_pkg::COLOR_W-1:0]   out_color,
  output logic [dtpg_pkg::ADDR_W-1:0]    out_addr,
  output logic                           out_write
);

  localparam int KW = 7;

  logic                           valid_r, ld;
  logic [dtpg_pkg::COLOR_W-1:0]   color_r, color_nxt;
  logic [dtpg_pkg::ADDR_W-1:0]    addr_r;
  logic                           write_r;
  logic [KW-1:0]                  k_full;
  logic [2:0]                     k;

  assign ld       = !valid_r || out_ready;
  assign in_ready = ld;

  // palette index wraps modulo 8 for large grids
  assign k_full    = KW'(in_row) * KW'(GRID_COLS) + KW'(in_col);
  assign k         = k_full[2:0];
  assign color_nxt = in_side.use_tile ? palette[{k, 3'b000} +: dtpg_pkg::COLOR_W]
                                      : in_side.color_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      color_r <= color_nxt;
      addr_r  <= in_side.addr;
      write_r <= in_side.wr;
    end
  end

  assign out_valid = valid_r;
  assign out_color = color_r;
  assign out_addr  = addr_r;
  assign out_write = write_r;

endmodule

[design/display_test_pattern_generator_top.sv]
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | tdata: pixel_x, pixel_y; tuser: frame_begin
// out_    | out | out_tvalid/out_tready| tdata: pixel_color, pixel_address, pixel_write
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (one register per write)
//
// One item per cycle sustained while out_tready stays high. An item takes 13
// register stages: input capture, window/band stage, a 10-stage restoring
// divider (one quotient bit per stage, sized by the 10-bit x offset) and the
// output register. Each stage holds its own valid bit and loads when it is
// empty or its successor loads, so bubbles close up under an output stall.
// Synchronous active-low reset clears valids and the band counter and loads
// the register file defaults.
module display_test_pattern_generator_top #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 480,
  parameter int GRID_ROWS     = 2,
  parameter int GRID_COLS     = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // [9:0] pixel_x, [18:10] pixel_y
  input  logic                               in_tuser,   // [0] frame_begin
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // [7:0] pixel_color,
                                                         // [26:8] pixel_address,
                                                         // [27] pixel_write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dtpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dtpg_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int CQW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RQW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  dtpg_pkg::cfg_t                 cfg_r, cfg_nxt;

  logic                           dv_valid, dv_ready;
  logic [dtpg_pkg::X_W-1:0]       dv_rx;
  logic [dtpg_pkg::Y_W-1:0]       dv_ry;
  dtpg_pkg::side_t                dv_side;
  logic [dtpg_pkg::PHASE_W-1:0]   band_phase;

  logic                           ot_valid, ot_ready;
  logic [CQW-1:0]                 ot_col;
  logic [RQW-1:0]                 ot_row;
  dtpg_pkg::side_t                ot_side;

  logic [dtpg_pkg::COLOR_W-1:0]   pix_color;
  logic [dtpg_pkg::ADDR_W-1:0]    pix_addr;
  logic                           pix_write;

  // Register file, read live by every stage; user must keep it written only while idle
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (dtpg_pkg::cfg_reg_t'(cfg_index))
        dtpg_pkg::REG_MODE:    cfg_nxt.mode    = cfg_data[0];
        dtpg_pkg::REG_LEFT:    cfg_nxt.left    = cfg_data[dtpg_pkg::X_W-1:0];
        dtpg_pkg::REG_TOP:     cfg_nxt.top     = cfg_data[dtpg_pkg::Y_W-1:0];
        dtpg_pkg::REG_RWIDTH:  cfg_nxt.rwidth  = cfg_data[dtpg_pkg::X_W-1:0];
        dtpg_pkg::REG_RHEIGHT: cfg_nxt.rheight = cfg_data[dtpg_pkg::Y_W-1:0];
        dtpg_pkg::REG_CELLW:   cfg_nxt.cellw   = cfg_data[dtpg_pkg::X_W-1:0];
        dtpg_pkg::REG_CELLH:   cfg_nxt.cellh   = cfg_data[dtpg_pkg::Y_W-1:0];
        dtpg_pkg::REG_PALETTE: cfg_nxt.palette = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= 1'b0;
      cfg_r.left    <= 10'd150;
      cfg_r.top     <= 9'd40;
      cfg_r.rwidth  <= 10'd500;
      cfg_r.rheight <= 9'd400;
      cfg_r.cellw   <= 10'd100;
      cfg_r.cellh   <= 9'd100;
      cfg_r.palette <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: capture, band counter, window tests, address
  dtpg_front #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_x       (in_tdata[9:0]),
    .in_y       (in_tdata[18:10]),
    .in_fb      (in_tuser),
    .dv_valid   (dv_valid),
    .dv_ready   (dv_ready),
    .dv_rx      (dv_rx),
    .dv_ry      (dv_ry),
    .dv_side    (dv_side),
    .band_phase (band_phase)
  );

  // Cell column/row: offset over cell size, modulo grid size
  dtpg_div #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_rx     (dv_rx),
    .in_ry     (dv_ry),
    .in_side   (dv_side),
    .out_valid (ot_valid),
    .out_ready (ot_ready),
    .out_col   (ot_col),
    .out_row   (ot_row),
    .out_side  (ot_side)
  );

  // Palette lookup and output register
  dtpg_out #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .palette   (cfg_r.palette),
    .in_valid  (ot_valid),
    .in_ready  (ot_ready),
    .in_col    (ot_col),
    .in_row    (ot_row),
    .in_side   (ot_side),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_color (pix_color),
    .out_addr  (pix_addr),
    .out_write (pix_write)
  );

  assign out_tdata = {4'b0000, pix_write, pix_addr, pix_color};

  // Band counter always moves in whole steps
  assert property (@(posedge clk) disable iff (!rst_n)
    band_phase[2:0] == 3'b000)
    else $error("band phase off its step grid");

  // Band counter moves only on an accepted frame start
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_tvalid && in_tready && in_tuser) |-> $stable(band_phase))
    else $error("band phase moved without a frame start");

  // A pixel that is not written carries a blank colour
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !pix_write |-> pix_color == '0)
    else $error("colour set on an unwritten pixel");

endmodule

[bench/pattern_checker.sv]
`timescale 1ns / 1ps

// Watches the pixel, result and register channels, keeps its own copy of the
// registers and the band counter, and compares every result item in order.
module pattern_checker #(
  parameter int CANVAS_WIDTH  = 800,
  parameter int CANVAS_HEIGHT = 480,
  parameter int GRID_ROWS     = 2,
  parameter int GRID_COLS     = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [23:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [31:0]                    out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtpg_pkg::CFG_DAT_W-1:0] cfg_data,
  output int unsigned                    pending_pixels,
  output int unsigned                    mismatch_count
);

  typedef struct packed {
    logic [dtpg_pkg::COLOR_W-1:0] color;
    logic [dtpg_pkg::ADDR_W-1:0]  addr;
    logic                         wr;
  } pixel_t;

  dtpg_pkg::cfg_t               regs;
  logic [dtpg_pkg::PHASE_W-1:0] band_phase;
  pixel_t                       expected_pixels[$];

  // Colour, address and write flag of one pixel; band_phase already stepped
  function automatic pixel_t render_pixel(logic [dtpg_pkg::X_W-1:0] x,
                                          logic [dtpg_pkg::Y_W-1:0] y);
    pixel_t                       p;
    bit                           on_canvas;
    bit                           in_rect;
    int                           cw;
    int                           ch;
    int                           col;
    int                           row;
    int                           k;
    logic [dtpg_pkg::COLOR_W-1:0] r;
    logic [dtpg_pkg::COLOR_W-1:0] g;
    logic [dtpg_pkg::COLOR_W-1:0] b;
    p.addr    = dtpg_pkg::ADDR_W'(int'(y) * CANVAS_WIDTH + int'(x));
    p.color   = '0;
    p.wr      = 1'b0;
    on_canvas = int'(x) < CANVAS_WIDTH && int'(y) < CANVAS_HEIGHT;
    if (regs.mode) begin
      if (on_canvas) begin
        r       = band_phase + x[7:0] + y[7:0];
        g       = band_phase - y[7:0];
        b       = band_phase + y[7:0];
        p.color = (r & dtpg_pkg::MASK_RG) |
                  ((g & dtpg_pkg::MASK_RG) >> 3) |
                  ((b & dtpg_pkg::MASK_B) >> 6);
        p.wr    = 1'b1;
      end
    end else begin
      in_rect = on_canvas &&
                int'(x) >= int'(regs.left) && int'(x) < int'(regs.left) + int'(regs.rwidth) &&
                int'(y) >= int'(regs.top) && int'(y) < int'(regs.top) + int'(regs.rheight);
      if (in_rect) begin
        // zero cell size behaves as one pixel
        cw      = (regs.cellw == 0) ? 1 : int'(regs.cellw);
        ch      = (regs.cellh == 0) ? 1 : int'(regs.cellh);
        col     = ((int'(x) - int'(regs.left)) / cw) % GRID_COLS;
        row     = ((int'(y) - int'(regs.top)) / ch) % GRID_ROWS;
        k       = (row * GRID_COLS + col) % 8;
        p.color = regs.palette[8*k +: 8];
        p.wr    = 1'b1;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      regs.mode    = 1'b0;
      regs.left    = dtpg_pkg::X_W'(150);
      regs.top     = dtpg_pkg::Y_W'(40);
      regs.rwidth  = dtpg_pkg::X_W'(500);
      regs.rheight = dtpg_pkg::Y_W'(400);
      regs.cellw   = dtpg_pkg::X_W'(100);
      regs.cellh   = dtpg_pkg::Y_W'(100);
      regs.palette = '0;
      band_phase   = '0;
      expected_pixels.delete();
      pending_pixels <= 0;
      mismatch_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (dtpg_pkg::cfg_reg_t'(cfg_index))
          dtpg_pkg::REG_MODE:    regs.mode    = cfg_data[0];
          dtpg_pkg::REG_LEFT:    regs.left    = cfg_data[dtpg_pkg::X_W-1:0];
          dtpg_pkg::REG_TOP:     regs.top     = cfg_data[dtpg_pkg::Y_W-1:0];
          dtpg_pkg::REG_RWIDTH:  regs.rwidth  = cfg_data[dtpg_pkg::X_W-1:0];
          dtpg_pkg::REG_RHEIGHT: regs.rheight = cfg_data[dtpg_pkg::Y_W-1:0];
          dtpg_pkg::REG_CELLW:   regs.cellw   = cfg_data[dtpg_pkg::X_W-1:0];
          dtpg_pkg::REG_CELLH:   regs.cellh   = cfg_data[dtpg_pkg::Y_W-1:0];
          dtpg_pkg::REG_PALETTE: regs.palette = cfg_data;
          default: ;
        endcase
      end

      // results first, so an item accepted on this edge is never matched here
      if (out_tvalid && out_tready) begin
        got.color = out_tdata[7:0];
        got.addr  = out_tdata[26:8];
        got.wr    = out_tdata[27];
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected pixel color %02h addr %0d wr %0b",
                     $realtime, got.color, got.addr, got.wr);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (got.color !== want.color || got.addr !== want.addr || got.wr !== want.wr) begin
            if (mismatch_count < 10)
              $display("%0t: pixel mismatch exp color %02h addr %0d wr %0b, got %02h %0d %0b",
                       $realtime, want.color, want.addr, want.wr,
                       got.color, got.addr, got.wr);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (regs.mode && in_tuser)
          band_phase = band_phase + dtpg_pkg::PHASE_STEP;
        expected_pixels.push_back(render_pixel(in_tdata[9:0], in_tdata[18:10]));
      end

      pending_pixels <= expected_pixels.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Pattern generator bench: directed corner pixels in both modes, then eight
// segments of mostly raster-ordered pixels with random jumps and some noise,
// each under its own register setting and idle/stall profile.
module tb_top;

  localparam int X_W               = dtpg_pkg::X_W;
  localparam int Y_W               = dtpg_pkg::Y_W;
  localparam int CFG_IDX_W         = dtpg_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W         = dtpg_pkg::CFG_DAT_W;
  localparam int CLK_HALF          = 10;
  localparam int CANVAS_WIDTH      = 800;
  localparam int CANVAS_HEIGHT     = 480;
  localparam int GRID_ROWS         = 2;
  localparam int GRID_COLS         = 4;
  localparam int SEGMENTS          = 8;
  localparam int ITEMS_PER_SEGMENT = 140;
  localparam int LONG_HOLD         = 200;   // receiver hold-off, well past pipe depth
  localparam int DRAIN_PAD         = 16;    // pipeline is 13 stages deep
  localparam int STALL_LIMIT       = 3000;  // cycles with no handshake at all

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int unsigned pending_pixels;
  int unsigned mismatch_count;

  // idle/stall profile of the current segment, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;

  // raster position for well-formed scans
  int scan_x = 0;
  int scan_y = 0;

  int stall_cycles = 0;

  always #(CLK_HALF) clk = ~clk;

  display_test_pattern_generator_top #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLS    (GRID_COLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pattern_checker #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLS    (GRID_COLS)
  ) pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_pixels(pending_pixels),
    .mismatch_count(mismatch_count)
  );

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // pipe fills and in_tready has to drop while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Entered and left at a falling edge; valid stays up between back-to-back items
  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic frame_begin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, y, x};
    in_tuser  <= frame_begin;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mostly a raster scan with frame_begin on the first pixel, with jumps to
  // new frames or random spots; the rest is noise over the full field range
  task automatic send_random_pixel();
    int             pick;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           fb;
    pick = $urandom_range(99);
    if (pick < 15) begin
      x  = X_W'($urandom_range(1023));
      y  = Y_W'($urandom_range(511));
      fb = 1'($urandom_range(1));
    end else begin
      if (pick < 18) begin
        scan_x = 0;
        scan_y = 0;
      end else if (pick < 28) begin
        scan_x = $urandom_range(CANVAS_WIDTH - 1);
        scan_y = $urandom_range(CANVAS_HEIGHT - 1);
      end
      x  = X_W'(scan_x);
      y  = Y_W'(scan_y);
      fb = (scan_x == 0 && scan_y == 0);
      scan_x++;
      if (scan_x == CANVAS_WIDTH) begin
        scan_x = 0;
        scan_y = (scan_y + 1) % CANVAS_HEIGHT;
      end
    end
    send_pixel(x, y, fb);
  endtask

  task automatic write_reg(input dtpg_pkg::cfg_reg_t idx,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Every register is rewritten each time, so all eight see several values
  task automatic write_setting(input dtpg_pkg::cfg_t s);
    write_reg(dtpg_pkg::REG_MODE,    CFG_DAT_W'(s.mode));
    write_reg(dtpg_pkg::REG_LEFT,    CFG_DAT_W'(s.left));
    write_reg(dtpg_pkg::REG_TOP,     CFG_DAT_W'(s.top));
    write_reg(dtpg_pkg::REG_RWIDTH,  CFG_DAT_W'(s.rwidth));
    write_reg(dtpg_pkg::REG_RHEIGHT, CFG_DAT_W'(s.rheight));
    write_reg(dtpg_pkg::REG_CELLW,   CFG_DAT_W'(s.cellw));
    write_reg(dtpg_pkg::REG_CELLH,   CFG_DAT_W'(s.cellh));
    write_reg(dtpg_pkg::REG_PALETTE, s.palette);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, let every outstanding pixel come out, then a few spare cycles
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic dtpg_pkg::cfg_t segment_setting(input int seg);
    dtpg_pkg::cfg_t s;
    s.mode    = 1'((seg % 2) ^ (seg / 4));
    s.left    = X_W'(150);
    s.top     = Y_W'(40);
    s.rwidth  = X_W'(500);
    s.rheight = Y_W'(400);
    s.cellw   = X_W'(100);
    s.cellh   = Y_W'(100);
    s.palette = {$urandom(), $urandom()};
    case (seg)
      1, 6: begin
        s.left    = X_W'($urandom_range(1023));
        s.top     = Y_W'($urandom_range(511));
        s.rwidth  = X_W'($urandom_range(1023));
        s.rheight = Y_W'($urandom_range(511));
        s.cellw   = X_W'($urandom_range(1023));
        s.cellh   = Y_W'($urandom_range(511));
      end
      2: begin
        // whole canvas, zero-sized cells
        s.left    = '0;
        s.top     = '0;
        s.rwidth  = X_W'(CANVAS_WIDTH);
        s.rheight = Y_W'(CANVAS_HEIGHT);
        s.cellw   = '0;
        s.cellh   = '0;
      end
      3: begin
        s.left    = '1;
        s.top     = '1;
        s.rwidth  = '1;
        s.rheight = '1;
        s.cellw   = '1;
        s.cellh   = '1;
        s.palette = '1;
      end
      4: begin
        s.left    = '0;
        s.top     = '0;
        s.rwidth  = '0;
        s.rheight = '0;
        s.cellw   = '0;
        s.cellh   = '0;
        s.palette = '0;
      end
      5: begin
        // small cells so the grid wraps many times inside the rectangle
        s.left    = X_W'($urandom_range(CANVAS_WIDTH - 1));
        s.top     = Y_W'($urandom_range(CANVAS_HEIGHT - 1));
        s.rwidth  = X_W'($urandom_range(CANVAS_WIDTH));
        s.rheight = Y_W'($urandom_range(CANVAS_HEIGHT));
        s.cellw   = X_W'($urandom_range(40, 1));
        s.cellh   = Y_W'($urandom_range(40, 1));
      end
      7: begin
        // rectangle spills off the canvas, canvas-sized cells
        s.left    = '0;
        s.top     = '0;
        s.rwidth  = '1;
        s.rheight = '1;
        s.cellw   = X_W'(CANVAS_WIDTH);
        s.cellh   = Y_W'(CANVAS_HEIGHT);
      end
      default: ;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    dtpg_pkg::cfg_t setting;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dtpg_pkg::REG_MODE;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, tiled: default rectangle 150..649 x 40..439, 100x100 cells
    setting         = segment_setting(0);
    setting.palette = 64'h8040_2010_0804_0201 ^ 64'hE0E0_1C1C_0303_FF00;
    write_setting(setting);
    send_pixel(X_W'(0),    Y_W'(0),    1'b1);   // frame start ignored in tiled mode
    send_pixel(X_W'(150),  Y_W'(40),   1'b0);   // top-left corner of rectangle
    send_pixel(X_W'(249),  Y_W'(139),  1'b0);   // last pixel of first cell
    send_pixel(X_W'(250),  Y_W'(40),   1'b0);
    send_pixel(X_W'(450),  Y_W'(40),   1'b0);   // last column of grid
    send_pixel(X_W'(550),  Y_W'(40),   1'b0);   // grid wraps horizontally
    send_pixel(X_W'(150),  Y_W'(140),  1'b0);
    send_pixel(X_W'(350),  Y_W'(240),  1'b0);   // grid wraps vertically
    send_pixel(X_W'(649),  Y_W'(439),  1'b0);   // bottom-right corner
    send_pixel(X_W'(650),  Y_W'(439),  1'b0);   // just right of rectangle
    send_pixel(X_W'(149),  Y_W'(40),   1'b0);   // just left
    send_pixel(X_W'(150),  Y_W'(39),   1'b0);   // just above
    send_pixel(X_W'(150),  Y_W'(440),  1'b0);   // just below
    send_pixel(X_W'(799),  Y_W'(479),  1'b0);
    send_pixel(X_W'(800),  Y_W'(0),    1'b0);   // off the canvas
    send_pixel(X_W'(0),    Y_W'(480),  1'b0);
    send_pixel(X_W'(1023), Y_W'(511),  1'b1);
    drain();

    // Directed, oblique: band counter steps, off-canvas pixels still step it
    setting.mode = 1'b1;
    write_setting(setting);
    send_pixel(X_W'(0),    Y_W'(0),    1'b1);
    send_pixel(X_W'(799),  Y_W'(479),  1'b0);
    send_pixel(X_W'(1023), Y_W'(511),  1'b1);
    send_pixel(X_W'(255),  Y_W'(255),  1'b0);
    send_pixel(X_W'(100),  Y_W'(200),  1'b1);
    send_pixel(X_W'(800),  Y_W'(100),  1'b0);
    drain();

    // Random segments; idle profile cycles none / sender / receiver / both
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      write_setting(segment_setting(seg));
      if (seg % 4 == 0)
        hold_off_req = 1'b1;
      repeat (ITEMS_PER_SEGMENT) send_random_pixel();
      drain();
    end

    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
